FILE: rtl/core/pdc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdc_pkg: shared types for the packet deframer with checksum check
// Item structures for both channels and the frame position codes.
// ----------------------------------------------------------------------------
package pdc_pkg;

    // One input item: a wire byte and its start-of-packet marker.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       packet_start;
    } t_in_item;

    // One result item: a passed-through data byte or an end-of-packet summary.
    typedef struct packed {
        logic        is_summary;
        logic [7:0]  payload_byte;
        logic [7:0]  packet_id;
        logic [7:0]  payload_length;
        logic [31:0] stamp;
        logic        checksum_ok;
    } t_out_item;

    // Position inside the frame: which byte is expected next.
    typedef enum logic [3:0] {
        POS_IDLE   = 4'd0,
        POS_LEN    = 4'd1,
        POS_TS0    = 4'd2,
        POS_TS1    = 4'd3,
        POS_TS2    = 4'd4,
        POS_TS3    = 4'd5,
        POS_CHK_LO = 4'd6,
        POS_CHK_HI = 4'd7,
        POS_DATA   = 4'd8
    } t_pos;

endpackage
`default_nettype wire

FILE: rtl/core/pdc_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdc_in_if: input byte channel
// Carries valid, ready and one input item from source to sink.
// ----------------------------------------------------------------------------
interface pdc_in_if;
    import pdc_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/pdc_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pdc_out_if: result channel
// Carries valid, ready and one result item from source to sink.
// ----------------------------------------------------------------------------
interface pdc_out_if;
    import pdc_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/packet_deframer_checksum_check_top.sv
`default_nettype none
// Pipeline: an accepted input item is held in the input register; the result
// item it produces, if any, is then written to the result register, and an
// item waits in the input register while the sink stalls.
// Throughput: one input item per cycle while the sink does not stall; the frame state updates in one pass.
// Reset: synchronous, active low; no packet is open, sums and held fields are
// cleared and both pipeline registers are empty.
// ----------------------------------------------------------------------------
// packet_deframer_checksum_check_top: packet deframer with checksum check
// Parses id, length, timestamp and checksum header bytes, passes data bytes
// through and closes each packet with a summary carrying a checksum match flag.
// ----------------------------------------------------------------------------
module packet_deframer_checksum_check_top (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    pdc_in_if.sink     i_in,
    pdc_out_if.source  o_out
);
    import pdc_pkg::*;

    // Pipeline registers.
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    // Frame state.
    t_pos        r_pos, n_pos;
    logic [7:0]  r_remaining, n_remaining;
    logic [7:0]  r_low_sum, n_low_sum;
    logic [7:0]  r_high_sum, n_high_sum;
    logic [7:0]  r_id, n_id;
    logic [7:0]  r_length, n_length;
    logic [31:0] r_stamp, n_stamp;
    logic [15:0] r_check, n_check;

    // Result of the current pass.
    logic      n_emit;
    t_out_item n_out;

    logic       s2_go;
    logic [7:0] b;
    logic       start;
    logic [7:0] add_low;
    logic [7:0] add_high;
    logic [7:0] rem_dec;

    // Handshake: the second stage moves when the result register is free.
    assign s2_go       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || s2_go;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;

    assign b        = r_in_item.rx_byte;
    assign start    = r_in_item.packet_start;
    assign add_low  = r_low_sum + b;
    assign add_high = r_high_sum + add_low;
    assign rem_dec  = r_remaining - 8'd1;

    // Next frame position.
    always_comb begin
        n_pos = r_pos;
        if (start) begin
            n_pos = POS_LEN;
        end else begin
            case (r_pos)
                POS_LEN:    n_pos = POS_TS0;
                POS_TS0:    n_pos = POS_TS1;
                POS_TS1:    n_pos = POS_TS2;
                POS_TS2:    n_pos = POS_TS3;
                POS_TS3:    n_pos = POS_CHK_LO;
                POS_CHK_LO: n_pos = POS_CHK_HI;
                POS_CHK_HI: n_pos = (r_remaining == 8'd0) ? POS_IDLE : POS_DATA;
                POS_DATA:   n_pos = (rem_dec == 8'd0) ? POS_IDLE : POS_DATA;
                default:    n_pos = POS_IDLE;
            endcase
        end
    end

    // Sums, held header fields and remaining count.
    always_comb begin
        n_remaining = r_remaining;
        n_low_sum   = r_low_sum;
        n_high_sum  = r_high_sum;
        n_id        = r_id;
        n_length    = r_length;
        n_stamp     = r_stamp;
        n_check     = r_check;
        if (start) begin
            // A start marker opens a fresh packet and drops any open one.
            n_remaining = 8'd0;
            n_low_sum   = b;
            n_high_sum  = b;
            n_id        = b;
            n_length    = 8'd0;
            n_stamp     = 32'd0;
            n_check     = 16'd0;
        end else begin
            case (r_pos)
                POS_LEN: begin
                    n_length    = b;
                    n_remaining = b;
                    n_low_sum   = add_low;
                    n_high_sum  = add_high;
                end
                POS_TS0: begin
                    n_stamp[7:0] = r_stamp[7:0] | b;
                    n_low_sum    = add_low;
                    n_high_sum   = add_high;
                end
                POS_TS1: begin
                    n_stamp[15:8] = r_stamp[15:8] | b;
                    n_low_sum     = add_low;
                    n_high_sum    = add_high;
                end
                POS_TS2: begin
                    n_stamp[23:16] = r_stamp[23:16] | b;
                    n_low_sum      = add_low;
                    n_high_sum     = add_high;
                end
                POS_TS3: begin
                    n_stamp[31:24] = r_stamp[31:24] | b;
                    n_low_sum      = add_low;
                    n_high_sum     = add_high;
                end
                POS_CHK_LO: n_check[7:0]  = b;
                POS_CHK_HI: n_check[15:8] = b;
                POS_DATA: begin
                    n_low_sum   = add_low;
                    n_high_sum  = add_high;
                    n_remaining = rem_dec;
                end
                default: ;
            endcase
        end
    end

    // Result item for this pass.
    always_comb begin
        n_emit               = 1'b0;
        n_out.is_summary     = 1'b0;
        n_out.payload_byte   = 8'd0;
        n_out.packet_id      = r_id;
        n_out.payload_length = r_length;
        n_out.stamp          = r_stamp;
        n_out.checksum_ok    = 1'b0;
        if (!start) begin
            case (r_pos)
                POS_CHK_HI: begin
                    // Empty packet closes on the checksum high byte.
                    if (r_remaining == 8'd0) begin
                        n_emit            = 1'b1;
                        n_out.is_summary  = 1'b1;
                        n_out.checksum_ok = (r_low_sum == r_check[7:0]) &&
                                            (r_high_sum == b);
                    end
                end
                POS_DATA: begin
                    n_emit             = 1'b1;
                    n_out.payload_byte = b;
                    // The last data byte rides in the summary itself.
                    if (rem_dec == 8'd0) begin
                        n_out.is_summary  = 1'b1;
                        n_out.checksum_ok = (add_low == r_check[7:0]) &&
                                            (add_high == r_check[15:8]);
                    end
                end
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (s2_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item <= i_in.data;
        end
    end

    // Frame state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= POS_IDLE;
            r_remaining <= 8'd0;
            r_low_sum   <= 8'd0;
            r_high_sum  <= 8'd0;
            r_id        <= 8'd0;
            r_length    <= 8'd0;
            r_stamp     <= 32'd0;
            r_check     <= 16'd0;
            r_out_valid <= 1'b0;
        end else if (s2_go) begin
            r_pos       <= n_pos;
            r_remaining <= n_remaining;
            r_low_sum   <= n_low_sum;
            r_high_sum  <= n_high_sum;
            r_id        <= n_id;
            r_length    <= n_length;
            r_stamp     <= n_stamp;
            r_check     <= n_check;
            r_out_valid <= n_emit;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go && n_emit) begin
            r_out_item <= n_out;
        end
    end

    // A data-byte item never carries a match flag.
    a_ok_only_in_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_item.is_summary |-> !r_out_item.checksum_ok)
        else $error("checksum_ok set on a data-byte item");

    // A summary always closes the packet.
    a_summary_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_go && n_emit && n_out.is_summary |=> r_pos == POS_IDLE)
        else $error("packet still open after its summary");

    // While data flows, at least one data byte is still expected.
    a_data_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos == POS_DATA |-> r_remaining != 8'd0)
        else $error("data position with no bytes remaining");

    // A held input item is not lost while the second stage stalls.
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !s2_go |=> r_in_valid && $stable(r_in_item))
        else $error("stalled input item dropped or changed");

endmodule
`default_nettype wire

FILE: bench/packet_deframer_checksum_check_top_test.sv
// ----------------------------------------------------------------------------
// packet_deframer_checksum_check_top_test: self-checking bench for the deframer
// Feeds framed packets, broken frames and stray bytes into the block, predicts
// every passed-through byte and end-of-packet summary, and compares each result
// item field by field while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module packet_deframer_checksum_check_top_test;
    import pdc_pkg::*;

    // Frame tracker that predicts the results of each accepted wire byte.
    class deframe_scoreboard;
        t_pos        frame_pos;
        logic [7:0]  bytes_left;
        logic [7:0]  sum_lo;
        logic [7:0]  sum_hi;
        logic [7:0]  open_id;
        logic [7:0]  open_len;
        logic [31:0] open_stamp;
        logic [15:0] wire_check;
        t_out_item   expected_results[$];
        int          mismatches;

        function new();
            frame_pos  = POS_IDLE;
            bytes_left = '0;
            sum_lo     = '0;
            sum_hi     = '0;
            open_id    = '0;
            open_len   = '0;
            open_stamp = '0;
            wire_check = '0;
            mismatches = 0;
        endfunction

        function void accumulate(logic [7:0] b);
            sum_lo = sum_lo + b;
            sum_hi = sum_hi + sum_lo;
        endfunction

        function void push_result(logic summary, logic [7:0] b);
            t_out_item r;
            r.is_summary     = summary;
            r.payload_byte   = b;
            r.packet_id      = open_id;
            r.payload_length = open_len;
            r.stamp          = open_stamp;
            r.checksum_ok    = summary && (sum_lo == wire_check[7:0])
                               && (sum_hi == wire_check[15:8]);
            expected_results.push_back(r);
        endfunction

        // Advance the frame by one accepted byte.
        function void note_byte(t_in_item it);
            logic [7:0] b;
            b = it.rx_byte;
            if (it.packet_start) begin
                sum_lo     = '0;
                sum_hi     = '0;
                open_id    = b;
                open_len   = '0;
                open_stamp = '0;
                wire_check = '0;
                bytes_left = '0;
                accumulate(b);
                frame_pos  = POS_LEN;
                return;
            end
            case (frame_pos)
                POS_LEN: begin
                    open_len   = b;
                    bytes_left = b;
                    accumulate(b);
                    frame_pos  = POS_TS0;
                end
                POS_TS0, POS_TS1, POS_TS2, POS_TS3: begin
                    open_stamp[8 * (frame_pos - POS_TS0) +: 8] = b;
                    accumulate(b);
                    frame_pos = t_pos'(frame_pos + 4'd1);
                end
                POS_CHK_LO: begin
                    wire_check[7:0] = b;
                    frame_pos       = POS_CHK_HI;
                end
                POS_CHK_HI: begin
                    wire_check[15:8] = b;
                    if (bytes_left == 0) begin
                        push_result(1'b1, 8'h00);
                        frame_pos = POS_IDLE;
                    end else begin
                        frame_pos = POS_DATA;
                    end
                end
                POS_DATA: begin
                    accumulate(b);
                    bytes_left = bytes_left - 8'd1;
                    if (bytes_left == 0) begin
                        push_result(1'b1, b);
                        frame_pos = POS_IDLE;
                    end else begin
                        push_result(1'b0, b);
                    end
                end
                default: frame_pos = POS_IDLE;
            endcase
        endfunction

        function void report(string what, t_out_item want, t_out_item got);
            if (mismatches < 10) begin
                $display("%s: expected sum=%0b byte=%02h id=%02h len=%02h stamp=%08h ok=%0b",
                         what, want.is_summary, want.payload_byte, want.packet_id,
                         want.payload_length, want.stamp, want.checksum_ok);
                $display("    got      sum=%0b byte=%02h id=%02h len=%02h stamp=%08h ok=%0b",
                         got.is_summary, got.payload_byte, got.packet_id,
                         got.payload_length, got.stamp, got.checksum_ok);
            end
            mismatches++;
        endfunction

        // Compare one result item with the oldest prediction.
        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_results.size() == 0) begin
                report("unexpected result", '0, got);
                return;
            end
            want = expected_results.pop_front();
            if (got.is_summary !== want.is_summary || got.payload_byte !== want.payload_byte
                || got.packet_id !== want.packet_id
                || got.payload_length !== want.payload_length
                || got.stamp !== want.stamp || got.checksum_ok !== want.checksum_ok)
                report("result mismatch", want, got);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    pdc_in_if  in_if ();
    pdc_out_if out_if ();

    packet_deframer_checksum_check_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    deframe_scoreboard sb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int sent_items    = 0;

    always #5 i_clk = ~i_clk;

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    int hold_served = 0;
    int hold_left   = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = 240;
            out_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor both channels at each edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready)
                sb.note_byte(in_if.data);
            if (out_if.valid && out_if.ready)
                sb.check_result(out_if.data);
        end
    end

    // Offer one wire byte and hold it until the block takes it.
    task automatic send_item(input logic [7:0] wire_byte, input logic start_mark);
        t_in_item item_word;
        item_word.rx_byte      = wire_byte;
        item_word.packet_start = start_mark;
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= item_word;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    // Build a frame with its checksum and send it, whole or cut short.
    task automatic send_packet(input logic [7:0] pid, input logic [7:0] plen,
                               input logic [31:0] pstamp, input bit corrupt,
                               input int fill, input int cut_at);
        logic [7:0]  frame[$];
        logic [7:0]  body[$];
        logic [7:0]  run_lo;
        logic [7:0]  run_hi;
        logic [7:0]  data_byte;
        logic [15:0] check_word;
        int          send_n;
        run_lo = '0;
        run_hi = '0;
        frame.push_back(pid);
        frame.push_back(plen);
        for (int k = 0; k < 4; k++)
            frame.push_back(pstamp[8 * k +: 8]);
        foreach (frame[k]) begin
            run_lo = run_lo + frame[k];
            run_hi = run_hi + run_lo;
        end
        for (int k = 0; k < int'(plen); k++) begin
            data_byte = (fill < 0) ? 8'($urandom) : 8'(fill);
            body.push_back(data_byte);
            run_lo = run_lo + data_byte;
            run_hi = run_hi + run_lo;
        end
        check_word = {run_hi, run_lo};
        if (corrupt)
            check_word = check_word ^ (16'd1 << $urandom_range(15));
        frame.push_back(check_word[7:0]);
        frame.push_back(check_word[15:8]);
        foreach (body[k])
            frame.push_back(body[k]);
        send_n = (cut_at < 0) ? frame.size() : cut_at;
        for (int k = 0; k < send_n; k++)
            send_item(frame[k], k == 0);
        sent_items += send_n;
    endtask

    // Stimulus and end of run.
    initial begin
        int pick;
        int len_pick;
        int wait_cycles;
        sb = new();
        i_rst_n      <= 1'b0;
        in_if.valid  <= 1'b0;
        in_if.data   <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct <= 8;
        recv_idle_pct <= 54;
        @(posedge i_clk);

        // Stray byte while idle, then the extremes of the fields.
        send_item(8'hFF, 1'b0);
        send_packet(8'h00, 8'd0, 32'h0000_0000, 1'b0, 0, -1);
        send_packet(8'hFF, 8'd1, 32'hFFFF_FFFF, 1'b1, 8'hFF, -1);
        // A new start marker cuts the open packet short.
        send_packet(8'h5A, 8'd3, $urandom, 1'b0, -1, 2);
        send_packet(8'h12, 8'd0, 32'h8000_0001, 1'b0, -1, -1);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct <= 8;
                    recv_idle_pct <= 54;
                end
                1: begin
                    send_idle_pct <= 54;
                    recv_idle_pct <= 8;
                end
                default: begin
                    send_idle_pct <= 0;
                    recv_idle_pct <= 0;
                end
            endcase
            hold_requests <= hold_requests + 1;
            if (phase == 2)
                send_packet(8'($urandom), 8'd255, $urandom, 1'($urandom_range(1)), -1, -1);
            while (sent_items < 28 + 510 * (phase + 1)) begin
                len_pick = $urandom_range(99);
                if (len_pick < 80)
                    len_pick = $urandom_range(10);
                else if (len_pick < 97)
                    len_pick = $urandom_range(40, 11);
                else
                    len_pick = $urandom_range(254, 41);
                pick = $urandom_range(99);
                if (pick < 8) begin
                    repeat ($urandom_range(1, 3)) send_item(8'($urandom), 1'b0);
                end else if (pick < 22) begin
                    send_packet(8'($urandom), 8'(len_pick), $urandom,
                                $urandom_range(99) < 40, -1,
                                $urandom_range(1, 7 + len_pick));
                end else begin
                    send_packet(8'($urandom), 8'(len_pick), $urandom,
                                $urandom_range(99) < 40, -1, -1);
                end
            end
        end
        in_if.valid <= 1'b0;

        // Drain outstanding results, then allow the pipeline to settle.
        wait_cycles = 0;
        while (sb.expected_results.size() != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
